### rtl/dda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int CMD_DEPTH  = 2;
    localparam int OUT_DEPTH  = 2;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN
    } t_back_state;

    typedef struct packed {
        t_opcode                       opcode;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
    } t_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic                          last;
        logic                          no_line;
    } t_pixel;

    typedef struct packed {
        t_opcode                       op;
        logic signed [COORD_BITS-1:0]  x0;
        logic signed [COORD_BITS-1:0]  y0;
        logic [COORD_BITS-1:0]         dx_mag;
        logic [COORD_BITS-1:0]         dy_mag;
        logic                          dx_neg;
        logic                          dy_neg;
        logic [COORD_BITS-1:0]         len;
    } t_cmd;

endpackage

### rtl/dda_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_queue
// Small register FIFO with show-ahead read.
// ----------------------------------------------------------------------------
module dda_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/dda_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_front
// Classifies an input word: endpoint deltas, magnitudes, signs, step count.
// ----------------------------------------------------------------------------
module dda_front (
    input  dda_pkg::t_item i_item,
    output dda_pkg::t_cmd  o_cmd
);

    localparam int C = dda_pkg::COORD_BITS;

    logic [C:0] w_dx, w_dy, w_ax, w_ay;

    assign w_dx = {i_item.end_x[C-1], i_item.end_x} - {i_item.start_x[C-1], i_item.start_x};
    assign w_dy = {i_item.end_y[C-1], i_item.end_y} - {i_item.start_y[C-1], i_item.start_y};
    assign w_ax = w_dx[C] ? ((C+1)'(0) - w_dx) : w_dx;
    assign w_ay = w_dy[C] ? ((C+1)'(0) - w_dy) : w_dy;

    always_comb begin
        o_cmd.op     = i_item.opcode;
        o_cmd.x0     = i_item.start_x;
        o_cmd.y0     = i_item.start_y;
        o_cmd.dx_mag = w_ax[C-1:0];
        o_cmd.dy_mag = w_ay[C-1:0];
        o_cmd.dx_neg = w_dx[C];
        o_cmd.dy_neg = w_dy[C];
        o_cmd.len    = (w_ax[C-1:0] > w_ay[C-1:0]) ? w_ax[C-1:0] : w_ay[C-1:0];
    end

endmodule

### rtl/dda_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_back
// Line engine: restoring dividers for the increments, position accumulate
// and round-half-away-from-zero pixel output.
// ----------------------------------------------------------------------------
module dda_back #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dda_pkg::t_cmd   i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_pop,
    output dda_pkg::t_pixel o_pix,
    output logic            o_pix_push,
    input  logic            i_pix_full
);

    localparam int C  = dda_pkg::COORD_BITS;
    localparam int PW = C + FRAC_BITS;
    localparam int IW = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam logic [PW:0] RND_POS = (PW+1)'(1) << (FRAC_BITS - 1);
    localparam logic [PW:0] RND_NEG = RND_POS - (PW+1)'(1);
    localparam logic [C-1:0] ONE_STEP = C'(1);

    function automatic logic [C-1:0] round_coord(input logic [PW-1:0] p);
        logic [PW:0] s;
        s = {p[PW-1], p} + (p[PW-1] ? RND_NEG : RND_POS);
        return s[FRAC_BITS +: C];
    endfunction

    dda_pkg::t_back_state r_state, n_state;

    logic [PW-1:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [IW-1:0] r_inc_x, r_inc_y;
    logic [C-1:0]  r_steps, r_len;
    logic [C:0]    r_rem_x, r_rem_y, w_sub_x, w_sub_y;
    logic [QW-1:0] r_q_x, r_q_y, w_q_x, w_q_y;
    logic          r_neg_x, r_neg_y;
    logic [CW-1:0] r_cnt;
    logic          w_take, w_start, w_ge_x, w_ge_y;

    assign w_take  = i_cmd_valid && !i_pix_full && (r_state != dda_pkg::ST_DIV);
    assign w_start = (i_cmd.op == dda_pkg::OP_START);

    assign n_pos_x = r_pos_x + {{(PW-IW){r_inc_x[IW-1]}}, r_inc_x};
    assign n_pos_y = r_pos_y + {{(PW-IW){r_inc_y[IW-1]}}, r_inc_y};

    assign w_ge_x  = (r_rem_x >= {1'b0, r_len});
    assign w_ge_y  = (r_rem_y >= {1'b0, r_len});
    assign w_sub_x = w_ge_x ? (r_rem_x - {1'b0, r_len}) : r_rem_x;
    assign w_sub_y = w_ge_y ? (r_rem_y - {1'b0, r_len}) : r_rem_y;
    assign w_q_x   = {r_q_x[QW-2:0], w_ge_x};
    assign w_q_y   = {r_q_y[QW-2:0], w_ge_y};

    always_comb begin
        n_state = r_state;
        case (r_state)
            dda_pkg::ST_IDLE, dda_pkg::ST_RUN: begin
                if (w_take) begin
                    if (w_start) begin
                        n_state = (i_cmd.len == '0) ? dda_pkg::ST_IDLE : dda_pkg::ST_DIV;
                    end else if (r_state == dda_pkg::ST_RUN && r_steps == ONE_STEP) begin
                        n_state = dda_pkg::ST_IDLE;
                    end
                end
            end
            dda_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = dda_pkg::ST_RUN;
                end
            end
            default: n_state = dda_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop  = w_take;
        o_pix_push = w_take;
        o_pix      = '0;
        if (w_start) begin
            o_pix.pixel_x = i_cmd.x0;
            o_pix.pixel_y = i_cmd.y0;
            o_pix.last    = (i_cmd.len == '0);
        end else if (r_state == dda_pkg::ST_RUN) begin
            o_pix.pixel_x = round_coord(n_pos_x);
            o_pix.pixel_y = round_coord(n_pos_y);
            o_pix.last    = (r_steps == ONE_STEP);
        end else begin
            o_pix.no_line = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_start) begin
            r_pos_x <= {i_cmd.x0, {FRAC_BITS{1'b0}}};
            r_pos_y <= {i_cmd.y0, {FRAC_BITS{1'b0}}};
            r_rem_x <= {1'b0, i_cmd.dx_mag};
            r_rem_y <= {1'b0, i_cmd.dy_mag};
            r_neg_x <= i_cmd.dx_neg;
            r_neg_y <= i_cmd.dy_neg;
            r_q_x   <= '0;
            r_q_y   <= '0;
            r_len   <= i_cmd.len;
            r_steps <= i_cmd.len;
            r_cnt   <= CW'(FRAC_BITS);
        end else if (w_take && r_state == dda_pkg::ST_RUN) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_steps <= r_steps - 1'b1;
        end
        if (r_state == dda_pkg::ST_DIV) begin
            r_rem_x <= {w_sub_x[C-1:0], 1'b0};
            r_rem_y <= {w_sub_y[C-1:0], 1'b0};
            r_q_x   <= w_q_x;
            r_q_y   <= w_q_y;
            r_cnt   <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_inc_x <= r_neg_x ? (IW'(0) - {1'b0, w_q_x}) : {1'b0, w_q_x};
                r_inc_y <= r_neg_y ? (IW'(0) - {1'b0, w_q_y}) : {1'b0, w_q_y};
            end
        end
    end

endmodule

### rtl/dda_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: start words load endpoints, step words emit pixels.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------
//  input    | i_push / o_full    | i_item  (opcode, endpoints)
//  result   | o_empty / i_pop    | o_pixel (x, y, last, no_line)
//
//  A step word and a zero-length start word each emit one pixel word when the
//  line engine takes them. A start word with nonzero length emits its first
//  pixel at once and then holds the engine for the bit-serial increment
//  division. Words queue in front of the engine meanwhile, up to CMD_DEPTH.
//  Reset is synchronous, active low, empties both queues and idles the engine.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS,
    parameter int CMD_DEPTH = dda_pkg::CMD_DEPTH,
    parameter int OUT_DEPTH = dda_pkg::OUT_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dda_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output dda_pkg::t_pixel o_pixel,
    output logic            o_empty
);

    dda_pkg::t_cmd   w_cmd_in, w_cmd_out;
    dda_pkg::t_pixel w_pix;
    logic            w_cmd_empty, w_cmd_pop, w_pix_push, w_pix_full;

    dda_front u_front (
        .i_item (i_item),
        .o_cmd  (w_cmd_in)
    );

    dda_queue #(
        .WIDTH ($bits(dda_pkg::t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd_in),
        .o_full  (o_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    dda_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_valid (!w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_pix       (w_pix),
        .o_pix_push  (w_pix_push),
        .i_pix_full  (w_pix_full)
    );

    dda_queue #(
        .WIDTH ($bits(dda_pkg::t_pixel)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_pix_push),
        .i_data  (w_pix),
        .o_full  (w_pix_full),
        .i_pop   (i_pop),
        .o_data  (o_pixel),
        .o_empty (o_empty)
    );

endmodule
